// ----- src/pgmd_pkg.sv -----
// ----------------------------------------------------------------------------
// pgmd_pkg: shared types for the PGM stream decoder
// Byte classification beat, result beat, result kinds, error codes.
// ----------------------------------------------------------------------------
package pgmd_pkg;

  localparam int DimBitsDefault = 16;
  localparam int QueueDepth     = 2;

  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindPixel  = 2'd1,
    KindError  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ErrMagic     = 3'd0,
    ErrWidth     = 3'd1,
    ErrHeight    = 3'd2,
    ErrMaxval    = 3'd3,
    ErrMaxRange  = 3'd4,
    ErrPremature = 3'd5,
    ErrDimension = 3'd6
  } err_e;

  // One classified input byte, as it travels from front to back.
  typedef struct packed {
    logic       eos;
    logic [7:0] data;
    logic       is_ws;
    logic       is_eol;
    logic       is_hash;
    logic       is_digit;
    logic       is_p;
    logic       is_two;
    logic       is_five;
    logic [3:0] digit;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;
    logic [15:0] row;
    logic [15:0] col;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] maxg;
    logic        raw;
    err_e        err;
    logic        last;
  } res_t;

endpackage

// ----- src/pgmd_fifo.sv -----
// ----------------------------------------------------------------------------
// pgmd_fifo: small register queue
// First-word-fall-through queue with occupancy count and full/empty flags.
// ----------------------------------------------------------------------------
module pgmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- src/pgmd_front.sv -----
// ----------------------------------------------------------------------------
// pgmd_front: byte intake and classifier
// Tags each accepted byte with its character class and queues it for the back.
// ----------------------------------------------------------------------------
module pgmd_front #(
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_stream_i,
  output logic             full_o,
  input  logic             cmd_pop_i,
  output logic             cmd_valid_o,
  output pgmd_pkg::cmd_t   cmd_o
);
  import pgmd_pkg::*;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChTwo   = 8'h32;
  localparam logic [7:0] ChFive  = 8'h35;
  localparam logic [7:0] ChP     = 8'h50;

  cmd_t                 cls;
  logic [7:0]           digit_off;
  logic [$bits(cmd_t)-1:0] rdata;
  logic                 empty;

  always_comb begin
    digit_off    = data_byte_i - ChZero;
    cls          = '0;
    cls.eos      = end_of_stream_i;
    cls.data     = data_byte_i;
    cls.is_eol   = (data_byte_i == ChLf) || (data_byte_i == ChCr);
    cls.is_ws    = cls.is_eol || (data_byte_i == ChSpace) || (data_byte_i == ChTab);
    cls.is_hash  = (data_byte_i == ChHash);
    cls.is_digit = (data_byte_i >= ChZero) && (data_byte_i <= ChNine);
    cls.is_p     = (data_byte_i == ChP);
    cls.is_two   = (data_byte_i == ChTwo);
    cls.is_five  = (data_byte_i == ChFive);
    cls.digit    = digit_off[3:0];
  end

  pgmd_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cls),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (rdata),
    .empty_o (empty)
  );

  assign cmd_valid_o = !empty;
  assign cmd_o       = cmd_t'(rdata);

endmodule

// ----- src/pgmd_back.sv -----
// ----------------------------------------------------------------------------
// pgmd_back: header and pixel decoder
// Steps the PGM parse state machine once per classified byte.
// ----------------------------------------------------------------------------
module pgmd_back #(
  parameter int DIM_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  pgmd_pkg::cmd_t   cmd_i,
  output logic             cmd_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output pgmd_pkg::res_t   res_o
);
  import pgmd_pkg::*;

  localparam logic [16:0] AccMax  = 17'h1FFFF;
  localparam logic [16:0] GrayMax = 17'h0FFFF;
  localparam logic [16:0] DimMax  = 17'((1 << DIM_BITS) - 1);

  typedef enum logic [3:0] {
    PhMagic, PhMagicCmt, PhType,
    PhWSkip, PhWCmt, PhWNum,
    PhHSkip, PhHCmt, PhHNum,
    PhMSkip, PhMCmt, PhMNum,
    PhPix, PhWait
  } phase_e;

  typedef enum logic [1:0] {FieldW, FieldH, FieldM} field_e;

  phase_e              phase_q, phase_d;
  logic [16:0]         acc_q, acc_d;
  logic [DIM_BITS-1:0] width_q, width_d, height_q, height_d;
  logic [DIM_BITS-1:0] row_q, row_d, col_q, col_d;
  logic [15:0]         maxval_q, maxval_d;
  logic                raw_q, raw_d, seen_q, seen_d;
  logic [7:0]          hold_q, hold_d;

  logic        fire, at_last;
  logic        do_emit, do_fail, do_skip;
  logic [15:0] emit_val;
  err_e        fail_code;
  field_e      skip_f;
  logic [16:0] sat_in;

  function automatic logic [16:0] acc_step(logic [16:0] base, logic [3:0] d);
    logic [20:0] v;
    v = ({4'b0, base} << 3) + ({4'b0, base} << 1) + {17'b0, d};
    return (v > {4'b0, AccMax}) ? AccMax : v[16:0];
  endfunction

  assign fire      = cmd_valid_i && !res_full_i;
  assign cmd_pop_o = fire;
  assign at_last   = (row_q == height_q - DIM_BITS'(1)) && (col_q == width_q - DIM_BITS'(1));

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    width_d   = width_q;
    height_d  = height_q;
    maxval_d  = maxval_q;
    raw_d     = raw_q;
    row_d     = row_q;
    col_d     = col_q;
    hold_d    = hold_q;
    seen_d    = seen_q;
    res_o     = '0;
    res_push_o = 1'b0;
    do_emit   = 1'b0;
    do_fail   = 1'b0;
    do_skip   = 1'b0;
    emit_val  = '0;
    fail_code = ErrMagic;
    skip_f    = FieldW;
    sat_in    = (acc_q > GrayMax) ? GrayMax : acc_q;

    if (fire && cmd_i.eos) begin
      unique case (phase_q)
        PhMagic, PhMagicCmt, PhType: begin
          do_fail = 1'b1;
        end
        PhPix: begin
          if (!raw_q && seen_q && at_last) begin
            do_emit  = 1'b1;
            emit_val = sat_in[15:0];
          end else begin
            do_fail   = 1'b1;
            fail_code = ErrPremature;
          end
        end
        PhWait: ;
        default: begin
          do_fail   = 1'b1;
          fail_code = ErrPremature;
        end
      endcase
    end else if (fire) begin
      unique case (phase_q)
        PhMagic: begin
          if (cmd_i.is_hash) begin
            phase_d = PhMagicCmt;
          end else if (cmd_i.is_p) begin
            phase_d = PhType;
          end else if (!cmd_i.is_ws) begin
            do_fail = 1'b1;
          end
        end
        PhType: begin
          if (cmd_i.is_two || cmd_i.is_five) begin
            raw_d   = cmd_i.is_five;
            phase_d = PhWSkip;
          end else begin
            do_fail = 1'b1;
          end
        end
        PhMagicCmt: if (cmd_i.is_eol) phase_d = PhMagic;
        PhWCmt:     if (cmd_i.is_eol) phase_d = PhWSkip;
        PhHCmt:     if (cmd_i.is_eol) phase_d = PhHSkip;
        PhMCmt:     if (cmd_i.is_eol) phase_d = PhMSkip;
        PhWSkip: begin
          do_skip = 1'b1;
          skip_f  = FieldW;
        end
        PhHSkip: begin
          do_skip = 1'b1;
          skip_f  = FieldH;
        end
        PhMSkip: begin
          do_skip = 1'b1;
          skip_f  = FieldM;
        end
        PhWNum, PhHNum: begin
          if (cmd_i.is_digit) begin
            acc_d = acc_step(acc_q, cmd_i.digit);
          end else if (acc_q > DimMax) begin
            do_fail   = 1'b1;
            fail_code = ErrDimension;
          end else if (phase_q == PhWNum) begin
            width_d = acc_q[DIM_BITS-1:0];
            do_skip = 1'b1;
            skip_f  = FieldH;
          end else begin
            height_d = acc_q[DIM_BITS-1:0];
            do_skip  = 1'b1;
            skip_f   = FieldM;
          end
        end
        PhMNum: begin
          if (cmd_i.is_digit) begin
            acc_d = acc_step(acc_q, cmd_i.digit);
          end else if (!cmd_i.is_ws) begin
            do_fail   = 1'b1;
            fail_code = ErrMaxval;
          end else if (acc_q > GrayMax) begin
            do_fail   = 1'b1;
            fail_code = ErrMaxRange;
          end else begin
            maxval_d       = acc_q[15:0];
            acc_d          = '0;
            row_d          = '0;
            col_d          = '0;
            seen_d         = 1'b0;
            res_push_o     = 1'b1;
            res_o.kind     = KindHeader;
            res_o.width    = 16'(width_q);
            res_o.height   = 16'(height_q);
            res_o.maxg     = acc_q[15:0];
            res_o.raw      = raw_q;
            if (width_q == '0 || height_q == '0) begin
              res_o.last = 1'b1;
              phase_d    = PhWait;
            end else begin
              phase_d    = PhPix;
            end
          end
        end
        PhPix: begin
          if (raw_q) begin
            if (maxval_q[15:8] == '0) begin
              do_emit  = 1'b1;
              emit_val = {8'h00, cmd_i.data};
            end else if (!seen_q) begin
              hold_d = cmd_i.data;
              seen_d = 1'b1;
            end else begin
              seen_d   = 1'b0;
              do_emit  = 1'b1;
              emit_val = {hold_q, cmd_i.data};
            end
          end else if (cmd_i.is_digit) begin
            seen_d = 1'b1;
            acc_d  = acc_step(seen_q ? acc_q : 17'd0, cmd_i.digit);
          end else if (seen_q) begin
            seen_d   = 1'b0;
            do_emit  = 1'b1;
            emit_val = sat_in[15:0];
          end
        end
        PhWait: ;
        default: ;
      endcase
    end

    // Field search: a byte skips, opens a comment, starts a number or fails.
    if (do_skip) begin
      if (cmd_i.is_ws) begin
        unique case (skip_f)
          FieldW:  phase_d = PhWSkip;
          FieldH:  phase_d = PhHSkip;
          default: phase_d = PhMSkip;
        endcase
      end else if (cmd_i.is_hash) begin
        unique case (skip_f)
          FieldW:  phase_d = PhWCmt;
          FieldH:  phase_d = PhHCmt;
          default: phase_d = PhMCmt;
        endcase
      end else if (cmd_i.is_digit) begin
        acc_d = {13'b0, cmd_i.digit};
        unique case (skip_f)
          FieldW:  phase_d = PhWNum;
          FieldH:  phase_d = PhHNum;
          default: phase_d = PhMNum;
        endcase
      end else begin
        do_fail = 1'b1;
        unique case (skip_f)
          FieldW:  fail_code = ErrWidth;
          FieldH:  fail_code = ErrHeight;
          default: fail_code = ErrMaxval;
        endcase
      end
    end

    if (do_fail) begin
      res_push_o = 1'b1;
      res_o.kind = KindError;
      res_o.err  = fail_code;
      phase_d    = PhWait;
    end

    if (do_emit) begin
      res_push_o   = 1'b1;
      res_o.kind   = KindPixel;
      res_o.value  = emit_val;
      res_o.row    = 16'(row_q);
      res_o.col    = 16'(col_q);
      res_o.width  = 16'(width_q);
      res_o.height = 16'(height_q);
      res_o.maxg   = maxval_q;
      res_o.raw    = raw_q;
      if (at_last) begin
        res_o.last = 1'b1;
        phase_d    = PhWait;
      end else if (col_q == width_q - DIM_BITS'(1)) begin
        col_d = '0;
        row_d = row_q + DIM_BITS'(1);
      end else begin
        col_d = col_q + DIM_BITS'(1);
      end
    end

    // End of stream: return to the reset state after any final beat.
    if (fire && cmd_i.eos) begin
      phase_d  = PhMagic;
      acc_d    = '0;
      width_d  = '0;
      height_d = '0;
      maxval_d = '0;
      raw_d    = 1'b0;
      row_d    = '0;
      col_d    = '0;
      hold_d   = '0;
      seen_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhMagic;
      acc_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      maxval_q <= '0;
      raw_q    <= 1'b0;
      row_q    <= '0;
      col_q    <= '0;
      hold_q   <= '0;
      seen_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      width_q  <= width_d;
      height_q <= height_d;
      maxval_q <= maxval_d;
      raw_q    <= raw_d;
      row_q    <= row_d;
      col_q    <= col_d;
      hold_q   <= hold_d;
      seen_q   <= seen_d;
    end
  end

endmodule

// ----- src/pgm_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// pgm_stream_decoder: streaming PGM (P2/P5) decoder
// Bytes are registered in the intake queue and their results in the output queue.
// Throughput: one byte per cycle while the result queue has room (single-step parser).
// Results leave through a two-beat queue, so the intake keeps going while a
// result waits to be popped.
// Reset: rst_ni clears both queues and returns the parser to the magic search.
// ----------------------------------------------------------------------------
module pgm_stream_decoder #(
  parameter int DIM_BITS = pgmd_pkg::DimBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte intake
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  // Result queue
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [15:0] pixel_value_o,
  output logic [15:0] pixel_row_o,
  output logic [15:0] pixel_column_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic [15:0] max_gray_o,
  output logic        raw_format_o,
  output logic [2:0]  error_code_o,
  output logic        last_o
);
  import pgmd_pkg::*;

  // Classified byte beats from the front to the back.
  cmd_t  cmd;
  logic  cmd_valid, cmd_pop;

  // Result beats from the back into the output queue.
  res_t  res_in, res_out;
  logic  res_push, res_full;
  logic [$bits(res_t)-1:0] res_rdata;

  // Front: classify each byte and hold it in the intake queue.
  pgmd_front #(
    .DEPTH (QueueDepth)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .full_o          (full),
    .cmd_pop_i       (cmd_pop),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd)
  );

  // Back: advance the parser whenever a byte waits and the result queue has room.
  pgmd_back #(
    .DIM_BITS (DIM_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Output queue: parts the parser from the consumer's pop.
  pgmd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QueueDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_out        = res_t'(res_rdata);
  assign kind_o         = res_out.kind;
  assign pixel_value_o  = res_out.value;
  assign pixel_row_o    = res_out.row;
  assign pixel_column_o = res_out.col;
  assign image_width_o  = res_out.width;
  assign image_height_o = res_out.height;
  assign max_gray_o     = res_out.maxg;
  assign raw_format_o   = res_out.raw;
  assign error_code_o   = res_out.err;
  assign last_o         = res_out.last;

  // The back never drops a result into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result pushed into full queue");

  // The back only consumes a byte that is really queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> cmd_valid)
    else $error("byte popped from empty intake queue");

  // A pixel lies inside the image it belongs to.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KindPixel) |->
      (pixel_row_o < image_height_o && pixel_column_o < image_width_o))
    else $error("pixel position outside image");

  // Error beats carry no header or pixel content.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KindError) |->
      (image_width_o == '0 && pixel_value_o == '0 && last_o == 1'b0))
    else $error("error beat carries payload");

endmodule
